[sv/multipart_message_reassembler_top_assert.svh]
// assertion macros for the message reassembler
// expects clk and rst in the scope of each use
`ifndef MULTIPART_MESSAGE_REASSEMBLER_TOP_ASSERT_SVH
`define MULTIPART_MESSAGE_REASSEMBLER_TOP_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define MMR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MMR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/mmr_pkg.sv]
// shared types and constants of the multipart message reassembler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmr_pkg;

  localparam int MAX_BYTES   = 4096;
  localparam int CHUNK_BYTES = 27;
  localparam int ADDR_W      = $clog2(MAX_BYTES);
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_STARTED   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_STORED    = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_COMPLETE  = 3'd5,
    ST_TIMED_OUT = 3'd6,
    ST_READ      = 3'd7
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  sender;
    logic [15:0] msg_type;
    logic [12:0] length;
    logic        use_byte;
  } result_t;

endpackage

`default_nettype wire

[sv/multipart_message_reassembler_top.sv]
// multipart message reassembler: one item in, one result item out, per cycle while not stalled
// each accepted item is registered in s1 and then in s2, the output; one item per cycle sustained
// while the output is not stalled, set by the single write/read port of the 4096 byte store
// rst clears transfer state and the pipeline; the store is not cleared
// depends on mmr_pkg and multipart_message_reassembler_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "multipart_message_reassembler_top_assert.svh"

module multipart_message_reassembler_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // tdata: sender_id, segment_id, byte_in_chunk, data_byte, total_size,
  //        msg_type, read_address, zero pad
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [mmr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: mode
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: out_sender, out_type, out_length, out_byte, zero pad
  output logic [mmr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: status
  output logic [2:0]                           m_axis_tuser,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mmr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  // input fields
  logic [1:0]  in_mode;
  logic [7:0]  in_sender;
  logic [15:0] in_seg;
  logic [4:0]  in_lane;
  logic [7:0]  in_byte;
  logic [15:0] in_size;
  logic [15:0] in_type;
  logic [11:0] in_addr;

  assign in_mode   = s_axis_tuser;
  assign in_sender = s_axis_tdata[7:0];
  assign in_seg    = s_axis_tdata[23:8];
  assign in_lane   = s_axis_tdata[28:24];
  assign in_byte   = s_axis_tdata[36:29];
  assign in_size   = s_axis_tdata[52:37];
  assign in_type   = s_axis_tdata[68:53];
  assign in_addr   = s_axis_tdata[80:69];

  // configuration
  logic [15:0] timeout_ticks;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= mmr_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == mmr_pkg::REG_TIMEOUT)) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == mmr_pkg::REG_TIMEOUT) begin
      prdata = {16'd0, timeout_ticks};
    end
  end

  // transfer state
  logic        transfer_open, transfer_open_next;
  logic [12:0] expected_bytes, expected_bytes_next;
  logic [12:0] received_bytes, received_bytes_next;
  logic [7:0]  owner_sender, owner_sender_next;
  logic [15:0] owner_type, owner_type_next;
  logic [15:0] ticks_since_data, ticks_since_data_next;

  // pipeline: s1 holds an item whose store read is in flight, s2 is the output
  logic                    s1_valid;
  mmr_pkg::result_t        s1_res;
  mmr_pkg::result_t        res_next;
  logic                    s2_valid;
  mmr_pkg::result_t        s2_res;
  logic [7:0]              s2_byte;
  logic                    s1_move;
  logic                    in_fire;

  assign s1_move       = s1_valid && (!s2_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // store access
  logic [7:0]                 store_mem [mmr_pkg::MAX_BYTES];
  logic                       wr_en;
  logic [mmr_pkg::ADDR_W-1:0] wr_addr;
  logic                       rd_en;
  logic [mmr_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 rd_q;

  logic [15:0] seg_m1;
  logic [21:0] offset;
  logic [13:0] recv_inc;
  logic [15:0] ticks_inc;
  logic        data_ok;

  assign seg_m1    = in_seg - 16'd1;
  assign offset    = 22'(seg_m1) * 22'(mmr_pkg::CHUNK_BYTES) + 22'(in_lane);
  assign recv_inc  = {1'b0, received_bytes} + 14'd1;
  assign ticks_inc = (ticks_since_data == 16'hFFFF) ? ticks_since_data
                                                    : ticks_since_data + 16'd1;
  assign data_ok   = (in_seg != 16'd0) && transfer_open && (in_sender == owner_sender)
                     && (8'(in_lane) < 8'(mmr_pkg::CHUNK_BYTES))
                     && (offset < 22'(expected_bytes))
                     && (offset < 22'(mmr_pkg::MAX_BYTES));
  assign wr_addr   = offset[mmr_pkg::ADDR_W-1:0];
  assign rd_addr   = mmr_pkg::ADDR_W'(in_addr);

  always_comb begin
    transfer_open_next    = transfer_open;
    expected_bytes_next   = expected_bytes;
    received_bytes_next   = received_bytes;
    owner_sender_next     = owner_sender;
    owner_type_next       = owner_type;
    ticks_since_data_next = ticks_since_data;
    wr_en                 = 1'b0;
    rd_en                 = 1'b0;
    res_next.status       = mmr_pkg::ST_NONE;
    res_next.sender       = owner_sender;
    res_next.msg_type     = owner_type;
    res_next.length       = expected_bytes;
    res_next.use_byte     = 1'b0;
    unique case (mmr_pkg::mode_t'(in_mode))
      mmr_pkg::MODE_HEADER: begin
        transfer_open_next  = 1'b0;
        expected_bytes_next = 13'd0;
        received_bytes_next = 13'd0;
        if (32'(in_size) > mmr_pkg::MAX_BYTES) begin
          res_next.status   = mmr_pkg::ST_TOO_LARGE;
          res_next.sender   = in_sender;
          res_next.msg_type = in_type;
          res_next.length   = 13'd0;
        end else begin
          transfer_open_next    = 1'b1;
          expected_bytes_next   = in_size[12:0];
          owner_sender_next     = in_sender;
          owner_type_next       = in_type;
          ticks_since_data_next = 16'd0;
          res_next.status       = mmr_pkg::ST_STARTED;
          res_next.sender       = in_sender;
          res_next.msg_type     = in_type;
          res_next.length       = in_size[12:0];
        end
      end
      mmr_pkg::MODE_DATA: begin
        if (!data_ok) begin
          res_next.status = mmr_pkg::ST_IGNORED;
        end else begin
          wr_en                 = 1'b1;
          ticks_since_data_next = 16'd0;
          if (recv_inc >= {1'b0, expected_bytes}) begin
            transfer_open_next  = 1'b0;
            expected_bytes_next = 13'd0;
            received_bytes_next = 13'd0;
            res_next.status     = mmr_pkg::ST_COMPLETE;
          end else begin
            received_bytes_next = recv_inc[12:0];
            res_next.status     = mmr_pkg::ST_STORED;
          end
        end
      end
      mmr_pkg::MODE_TICK: begin
        if (transfer_open) begin
          ticks_since_data_next = ticks_inc;
          if (ticks_inc > timeout_ticks) begin
            transfer_open_next  = 1'b0;
            expected_bytes_next = 13'd0;
            received_bytes_next = 13'd0;
            res_next.status     = mmr_pkg::ST_TIMED_OUT;
          end
        end
      end
      mmr_pkg::MODE_READ: begin
        rd_en             = 1'b1;
        res_next.status   = mmr_pkg::ST_READ;
        res_next.use_byte = (32'(in_addr) < mmr_pkg::MAX_BYTES);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      store_mem[wr_addr] <= in_byte;
    end
    if (in_fire && rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_open    <= 1'b0;
      expected_bytes   <= 13'd0;
      received_bytes   <= 13'd0;
      owner_sender     <= 8'd0;
      owner_type       <= 16'd0;
      ticks_since_data <= 16'd0;
    end else if (in_fire) begin
      transfer_open    <= transfer_open_next;
      expected_bytes   <= expected_bytes_next;
      received_bytes   <= received_bytes_next;
      owner_sender     <= owner_sender_next;
      owner_type       <= owner_type_next;
      ticks_since_data <= ticks_since_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (m_axis_tready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res <= res_next;
    end
    if (s1_move) begin
      s2_res  <= s1_res;
      s2_byte <= s1_res.use_byte ? rd_q : 8'd0;
    end
  end

  assign m_axis_tvalid = s2_valid;
  assign m_axis_tuser  = s2_res.status;
  assign m_axis_tdata  = {3'd0, s2_byte, s2_res.length, s2_res.msg_type, s2_res.sender};

  `MMR_ASSERT_IMPL(a_closed_clear, !transfer_open,
    (expected_bytes == 13'd0) && (received_bytes == 13'd0), "closed transfer holds counts")
  `MMR_ASSERT_ALWAYS(a_recv_bound, received_bytes <= expected_bytes,
    "received count passed expected size")
  `MMR_ASSERT_IMPL(a_ready_empty, !s1_valid, s_axis_tready,
    "input stalled with empty read stage")
  `MMR_ASSERT_IMPL(a_out_source, $rose(m_axis_tvalid), $past(s1_valid),
    "result appeared without an item in the read stage")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for multipart_message_reassembler_top: directed and random
// header, data, tick and read items, checked against a transfer predictor
// depends on mmr_pkg and the reassembler rtl
module testbench;

  localparam logic [mmr_pkg::CFG_ADDR_W-1:0] TIMEOUT_ADDR =
    mmr_pkg::CFG_ADDR_W'(4 * int'(mmr_pkg::REG_TIMEOUT));
  localparam int PHASE_ITEMS = 275;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    mmr_pkg::mode_t mode;
    logic [7:0]     sender;
    logic [15:0]    seg;
    logic [4:0]     lane;
    logic [7:0]     dbyte;
    logic [15:0]    size;
    logic [15:0]    mtype;
    logic [11:0]    addr;
  } rx_item_t;

  typedef struct {
    mmr_pkg::status_t status;
    logic [7:0]       sender;
    logic [15:0]      mtype;
    logic [12:0]      length;
    logic [7:0]       data;
  } reply_t;

  typedef struct {
    rx_item_t it;
    reply_t   rep;
  } staged_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mmr_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mmr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mmr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multipart_message_reassembler_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // transfer state as the predictor sees it
  logic [15:0] timeout_reg = mmr_pkg::TIMEOUT_RESET;
  logic        xfer_open = 1'b0;
  logic [12:0] exp_len = '0;
  logic [12:0] got_len = '0;
  logic [7:0]  own_sender = '0;
  logic [15:0] own_type = '0;
  logic [15:0] idle_ticks = '0;
  logic [7:0]  msg_store [mmr_pkg::MAX_BYTES];
  bit          written_map [mmr_pkg::MAX_BYTES];
  int          written_addrs [$];

  staged_t items_to_send [$];
  reply_t  replies_due [$];
  staged_t next_up;
  reply_t  on_bus_reply;
  int      items_made = 0;
  int      mismatches = 0;
  int      send_idle_pct = 18;
  int      recv_idle_pct = 85;
  logic    hold_trigger = 1'b0;
  logic    hold_done = 1'b0;
  int      hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic void close_xfer();
    xfer_open = 1'b0;
    exp_len = '0;
    got_len = '0;
  endfunction

  function automatic reply_t reassemble(input rx_item_t it);
    reply_t r;
    int offset;
    logic [11:0] waddr;
    r = '{mmr_pkg::ST_NONE, own_sender, own_type, exp_len, 8'h00};
    case (it.mode)
      mmr_pkg::MODE_HEADER: begin
        close_xfer();
        if (int'(it.size) > mmr_pkg::MAX_BYTES) begin
          r = '{mmr_pkg::ST_TOO_LARGE, it.sender, it.mtype, 13'd0, 8'h00};
        end else begin
          xfer_open = 1'b1;
          exp_len = it.size[12:0];
          own_sender = it.sender;
          own_type = it.mtype;
          idle_ticks = '0;
          r = '{mmr_pkg::ST_STARTED, it.sender, it.mtype, exp_len, 8'h00};
        end
      end
      mmr_pkg::MODE_DATA: begin
        offset = (int'(it.seg) - 1) * mmr_pkg::CHUNK_BYTES + int'(it.lane);
        r.status = mmr_pkg::ST_IGNORED;
        if (it.seg != 0 && xfer_open && it.sender == own_sender
            && it.lane < mmr_pkg::CHUNK_BYTES
            && offset < int'(exp_len) && offset < mmr_pkg::MAX_BYTES) begin
          waddr = 12'(offset);
          msg_store[waddr] = it.dbyte;
          if (!written_map[waddr]) begin
            written_map[waddr] = 1'b1;
            written_addrs.push_back(offset);
          end
          got_len++;
          idle_ticks = '0;
          if (got_len >= exp_len) begin
            r.status = mmr_pkg::ST_COMPLETE;
            close_xfer();
          end else begin
            r.status = mmr_pkg::ST_STORED;
          end
        end
      end
      mmr_pkg::MODE_TICK: begin
        if (xfer_open) begin
          if (idle_ticks != 16'hFFFF) idle_ticks++;
          if (idle_ticks > timeout_reg) begin
            r.status = mmr_pkg::ST_TIMED_OUT;
            close_xfer();
          end
        end
      end
      default: begin
        r.status = mmr_pkg::ST_READ;
        r.data = msg_store[it.addr];
      end
    endcase
    return r;
  endfunction

  // stimulus helpers: fields unused by the mode stay random
  function automatic rx_item_t base_item(input mmr_pkg::mode_t m);
    rx_item_t it;
    it.mode = m;
    it.sender = 8'($urandom);
    it.seg = 16'($urandom);
    it.lane = 5'($urandom);
    it.dbyte = 8'($urandom);
    it.size = 16'($urandom);
    it.mtype = 16'($urandom);
    it.addr = 12'($urandom);
    return it;
  endfunction

  task automatic push(input rx_item_t it);
    staged_t s;
    s.it = it;
    s.rep = reassemble(it);
    items_to_send.push_back(s);
    items_made++;
  endtask

  task automatic push_header(input logic [7:0] snd, input logic [15:0] size,
                             input logic [15:0] typ);
    rx_item_t it;
    it = base_item(mmr_pkg::MODE_HEADER);
    it.sender = snd;
    it.size = size;
    it.mtype = typ;
    push(it);
  endtask

  task automatic push_data(input logic [7:0] snd, input logic [15:0] seg,
                           input logic [4:0] lane, input logic [7:0] b);
    rx_item_t it;
    it = base_item(mmr_pkg::MODE_DATA);
    it.sender = snd;
    it.seg = seg;
    it.lane = lane;
    it.dbyte = b;
    push(it);
  endtask

  task automatic push_data_at(input logic [7:0] snd, input int off);
    push_data(snd, 16'(off / mmr_pkg::CHUNK_BYTES + 1), 5'(off % mmr_pkg::CHUNK_BYTES),
              8'($urandom));
  endtask

  task automatic push_tick();
    push(base_item(mmr_pkg::MODE_TICK));
  endtask

  // reads only go to bytes that a stored item has written
  task automatic push_read(input logic [11:0] addr);
    rx_item_t it;
    it = base_item(mmr_pkg::MODE_READ);
    it.addr = addr;
    push(it);
  endtask

  task automatic push_random_read();
    if (written_addrs.size() == 0) push_tick();
    else push_read(12'(written_addrs[$urandom_range(written_addrs.size() - 1)]));
  endtask

  task automatic send_message();
    logic [7:0] snd;
    int size, n_data, sel, next_off, i, k;
    snd = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 4) size = $urandom_range(65535, mmr_pkg::MAX_BYTES + 1);
    else if (sel < 8) size = 0;
    else if (sel < 12) size = $urandom_range(mmr_pkg::MAX_BYTES, 3000);
    else size = $urandom_range(60, 1);
    push_header(snd, 16'(size), 16'($urandom));
    n_data = (size > 80) ? $urandom_range(20, 4) : size + $urandom_range(2);
    next_off = 0;
    for (i = 0; i < n_data; i++) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        if (timeout_reg <= 8 && $urandom_range(2) == 0) begin
          for (k = 0; k <= int'(timeout_reg); k++) push_tick();
        end else begin
          push_tick();
        end
      end else if (sel < 12) begin
        push_random_read();
      end else if (sel < 16) begin
        push_data_at(snd ^ 8'($urandom_range(255, 1)), next_off);
      end else if (sel < 19) begin
        push_data(snd, 16'd0, 5'($urandom_range(mmr_pkg::CHUNK_BYTES - 1)), 8'($urandom));
      end else if (sel < 22) begin
        push_data(snd, 16'($urandom_range(3, 1)),
                  5'($urandom_range(31, mmr_pkg::CHUNK_BYTES)), 8'($urandom));
      end else if (sel < 25) begin
        push_data(snd, 16'($urandom_range(65535, 153)), 5'($urandom), 8'($urandom));
      end else if (sel < 28) begin
        return;
      end else if (size == 0) begin
        push_data_at(snd, 0);
      end else if (size > 80 || sel < 35) begin
        push_data_at(snd, $urandom_range(size - 1));
      end else begin
        push_data_at(snd, next_off);
        next_off = (next_off + 1) % size;
      end
    end
  endtask

  task automatic run_random(input int target);
    while (items_made < target) send_message();
  endtask

  task automatic wait_drained();
    while (items_to_send.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    timeout_reg = val;
  endtask

  task automatic cfg_check();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= TIMEOUT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== timeout_reg)
      note_mismatch($sformatf("timeout_ticks read exp %0d got %0d", timeout_reg,
                              prdata[15:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) replies_due.push_back(on_bus_reply);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_up = items_to_send.pop_front();
          on_bus_reply = next_up.rep;
          s_axis_tdata <= {7'b0, next_up.it.addr, next_up.it.mtype, next_up.it.size,
                           next_up.it.dbyte, next_up.it.lane, next_up.it.seg,
                           next_up.it.sender};
          s_axis_tuser <= next_up.it.mode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = mmr_pkg::status_t'(m_axis_tuser);
        got.sender = m_axis_tdata[7:0];
        got.mtype = m_axis_tdata[23:8];
        got.length = m_axis_tdata[36:24];
        got.data = m_axis_tdata[44:37];
        if (replies_due.size() == 0) begin
          note_mismatch($sformatf("unexpected item status %0d", got.status));
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.sender !== want.sender
              || got.mtype !== want.mtype || got.length !== want.length
              || got.data !== want.data)
            note_mismatch($sformatf(
              "exp st %0d snd %h typ %h len %0d byte %h, got st %0d snd %h typ %h len %0d byte %h",
              want.status, want.sender, want.mtype, want.length, want.data,
              got.status, got.sender, got.mtype, got.length, got.data));
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_check();

    // directed: idle transfer, oversize, zero size, extremes of offsets and lanes
    push_tick();
    push_data(8'h00, 16'd1, 5'd0, 8'h11);
    push_header(8'hFF, 16'd4097, 16'hFFFF);
    push_header(8'h00, 16'd0, 16'h0000);
    push_data(8'h00, 16'd1, 5'd0, 8'h22);
    push_header(8'hA5, 16'd4096, 16'h1234);
    push_data(8'hA5, 16'd152, 5'd18, 8'hFF);
    push_data(8'hA5, 16'd1, 5'd0, 8'h00);
    push_data(8'hA5, 16'd0, 5'd3, 8'h33);
    push_data(8'hA5, 16'd1, 5'd31, 8'h44);
    push_data(8'h5A, 16'd1, 5'd1, 8'h55);
    push_data(8'hA5, 16'hFFFF, 5'd26, 8'h66);
    push_data(8'hA5, 16'd152, 5'd19, 8'h77);
    push_read(12'hFFF);
    push_read(12'h000);
    push_header(8'h3C, 16'hFFFF, 16'h0001);
    push_tick();
    push_header(8'h07, 16'd2, 16'h8000);
    push_data(8'h07, 16'd1, 5'd1, 8'hA0);
    push_data(8'h07, 16'd1, 5'd1, 8'hA1);
    push_read(12'h001);
    wait_drained();

    // shortest timeout in this test
    cfg_write(16'd1);
    cfg_check();
    push_header(8'h03, 16'd5, 16'h0042);
    push_tick();
    push_tick();
    push_header(8'h03, 16'd5, 16'h0043);
    push_data(8'h03, 16'd1, 5'd0, 8'h5C);
    push_tick();
    push_data(8'h03, 16'd1, 5'd1, 8'h5D);
    push_tick();
    push_tick();
    run_random(PHASE_ITEMS);
    wait_drained();

    // longest timeout, idling swapped, with a pause mid-way
    send_idle_pct = 85;
    recv_idle_pct = 18;
    cfg_write(16'd65535);
    cfg_check();
    run_random(items_made + PHASE_ITEMS / 2);
    wait_drained();
    run_random(items_made + PHASE_ITEMS / 2);
    wait_drained();

    // no idling, receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(16'd3);
    cfg_check();
    run_random(items_made + PHASE_ITEMS);
    hold_trigger <= 1'b1;
    wait_drained();

    cfg_write(mmr_pkg::TIMEOUT_RESET);
    cfg_check();
    run_random(items_made + PHASE_ITEMS);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
